// ===== rtl/swled_pkg.sv =====
// ============================================================================
// swled_pkg
// Shared constants and the seven-segment decode for the mm:ss stopwatch.
// ============================================================================
package swled_pkg;

    // Reset value of the ticks-per-second register.
    localparam logic [7:0] TPS_RESET = 8'd61;

    // Decimal point of an active-low segment pattern.
    localparam logic [7:0] SEG_DP = 8'h80;

    // A BCD digit as held by the counters.
    typedef logic [3:0] t_digit;

    // LED view modes.
    localparam logic [1:0] VIEW_OFF     = 2'd0;
    localparam logic [1:0] VIEW_PACKED  = 2'd1;
    localparam logic [1:0] VIEW_MINUTES = 2'd2;
    localparam logic [1:0] VIEW_SECONDS = 2'd3;

    // Active-low seven-segment pattern; codes above nine blank the digit.
    function automatic logic [7:0] seg_decode(input t_digit d);
        logic [7:0] pat;
        case (d)
            4'd0:    pat = 8'hc0;
            4'd1:    pat = 8'hf9;
            4'd2:    pat = 8'ha4;
            4'd3:    pat = 8'hb0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hf8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h90;
            default: pat = 8'hff;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/swled_if.sv =====
// ============================================================================
// swled_if
// Valid/ready channels of the stopwatch: button sample in, display beat out.
// ============================================================================
interface swled_in_if;
    logic valid;
    logic ready;
    logic timer_tick;
    logic start_level;
    logic stop_level;
    logic view_level;

    modport source (output valid, output timer_tick, output start_level,
                    output stop_level, output view_level, input ready);
    modport sink   (input valid, input timer_tick, input start_level,
                    input stop_level, input view_level, output ready);
endinterface

interface swled_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] seg_seconds_ones;
    logic [7:0] seg_seconds_tens;
    logic [7:0] seg_minutes_ones;
    logic [7:0] seg_minutes_tens;
    logic [7:0] led_byte;

    modport source (output valid, output seg_seconds_ones, output seg_seconds_tens,
                    output seg_minutes_ones, output seg_minutes_tens,
                    output led_byte, input ready);
    modport sink   (input valid, input seg_seconds_ones, input seg_seconds_tens,
                    input seg_minutes_ones, input seg_minutes_tens,
                    input led_byte, output ready);
endinterface

// ===== rtl/stopwatch_mm_ss_with_led_view.sv =====
// ============================================================================
// stopwatch_mm_ss_with_led_view
// BCD mm:ss stopwatch with seven-segment patterns and an LED bar view.
// ============================================================================
// Each input beat is one sample of the timer tick and the start, stop and view
// buttons; each produces exactly one output beat with the four active-low digit
// patterns (decimal point lit on the minutes ones digit) and the LED byte. The
// block takes one beat per clock unless the output stalls: a beat is captured in
// the input register, then the counters are updated and the result register
// loaded together once the result register has space. Throughput is set only
// by the output side; ready on the input follows the result register's space.
// The ticks-per-second register resets to 61; the user must write it through
// the configuration port only while no beat is in flight (not enforced here).
module stopwatch_mm_ss_with_led_view (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    swled_in_if.sink    i_in,
    swled_out_if.source o_out
);
    import swled_pkg::*;

    // Configuration and counter state.
    logic [7:0] r_tps;
    logic [7:0] r_prescaler, n_prescaler;
    t_digit     r_sec_ones, n_sec_ones;
    logic [2:0] r_sec_tens, n_sec_tens;
    t_digit     r_min_ones, n_min_ones;
    t_digit     r_min_tens, n_min_tens;
    logic       r_running, n_running;
    logic [2:0] r_prev_btn;
    logic [1:0] r_view, n_view;
    logic [7:0] r_led, n_led;

    // Input register.
    logic       r_s1_valid;
    logic       r_s1_tick;
    logic [2:0] r_s1_btn;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_seg_so, r_seg_st, r_seg_mo, r_seg_mt, r_out_led;

    // Handshake between the two stages.
    logic in_fire;
    logic out_load;

    // Intermediate values of one step.
    logic       tick_en;
    logic       sec_pulse;
    logic [7:0] pre_inc;
    t_digit     a_sec_ones, a_min_ones, a_min_tens;
    logic [2:0] a_sec_tens;
    logic [1:0] view_sec;
    logic [2:0] rise;
    logic       run_start;
    logic [7:0] secs_bin;

    assign out_load   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || out_load;
    assign in_fire    = i_in.valid && i_in.ready;

    // Prescaler and second pulse.
    always_comb begin
        tick_en   = r_s1_tick && r_running;
        pre_inc   = r_prescaler + 8'd1;
        sec_pulse = tick_en && (pre_inc >= r_tps);
        if (sec_pulse) begin
            n_prescaler = '0;
        end else if (tick_en) begin
            n_prescaler = pre_inc;
        end else begin
            n_prescaler = r_prescaler;
        end
    end

    // BCD advance by one second, wrapping 99:59 to 00:00.
    always_comb begin
        a_sec_ones = r_sec_ones;
        a_sec_tens = r_sec_tens;
        a_min_ones = r_min_ones;
        a_min_tens = r_min_tens;
        if (sec_pulse) begin
            if (r_sec_ones >= 4'd9) begin
                a_sec_ones = '0;
                if (r_sec_tens >= 3'd5) begin
                    a_sec_tens = '0;
                    if (r_min_ones >= 4'd9) begin
                        a_min_ones = '0;
                        a_min_tens = (r_min_tens >= 4'd9) ? 4'd0 : r_min_tens + 4'd1;
                    end else begin
                        a_min_ones = r_min_ones + 4'd1;
                    end
                end else begin
                    a_sec_tens = r_sec_tens + 3'd1;
                end
            end else begin
                a_sec_ones = r_sec_ones + 4'd1;
            end
        end
    end

    // LED byte, refreshed on each second; packed view gives way from 4 minutes on.
    always_comb begin
        view_sec = r_view;
        if (sec_pulse && r_view == VIEW_PACKED &&
            (a_min_ones > 4'd3 || a_min_tens != 4'd0)) begin
            view_sec = VIEW_MINUTES;
        end
        secs_bin = {4'd0, a_sec_ones} + {2'd0, a_sec_tens, 3'd0} + {4'd0, a_sec_tens, 1'b0};
        n_led = r_led;
        if (sec_pulse) begin
            case (view_sec)
                VIEW_OFF:     n_led = '0;
                VIEW_PACKED:  n_led = secs_bin + {a_min_ones[1:0], 6'd0};
                VIEW_MINUTES: n_led = {4'd0, a_min_ones} + {1'b0, a_min_tens, 3'd0}
                                    + {3'd0, a_min_tens, 1'b0};
                VIEW_SECONDS: n_led = secs_bin;
                default:      n_led = r_led;
            endcase
        end
    end

    // Button edges: start, then stop or clear, then view.
    always_comb begin
        rise       = r_s1_btn & ~r_prev_btn;
        run_start  = rise[0] ? 1'b1 : r_running;
        n_running  = run_start;
        n_sec_ones = a_sec_ones;
        n_sec_tens = a_sec_tens;
        n_min_ones = a_min_ones;
        n_min_tens = a_min_tens;
        if (rise[1]) begin
            if (run_start) begin
                n_running = 1'b0;
            end else begin
                n_sec_ones = '0;
                n_sec_tens = '0;
                n_min_ones = '0;
                n_min_tens = '0;
            end
        end
        n_view = rise[2] ? view_sec + 2'd1 : view_sec;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_tps <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_tick <= i_in.timer_tick;
            r_s1_btn  <= {i_in.view_level, i_in.stop_level, i_in.start_level};
        end
    end

    // Stopwatch state, stepped once per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescaler <= '0;
            r_sec_ones  <= '0;
            r_sec_tens  <= '0;
            r_min_ones  <= '0;
            r_min_tens  <= '0;
            r_running   <= 1'b0;
            r_prev_btn  <= '0;
            r_view      <= VIEW_OFF;
            r_led       <= '0;
        end else if (out_load) begin
            r_prescaler <= n_prescaler;
            r_sec_ones  <= n_sec_ones;
            r_sec_tens  <= n_sec_tens;
            r_min_ones  <= n_min_ones;
            r_min_tens  <= n_min_tens;
            r_running   <= n_running;
            r_prev_btn  <= r_s1_btn;
            r_view      <= n_view;
            r_led       <= n_led;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_seg_so  <= seg_decode(n_sec_ones);
            r_seg_st  <= seg_decode({1'b0, n_sec_tens});
            r_seg_mo  <= seg_decode(n_min_ones) ^ SEG_DP;
            r_seg_mt  <= seg_decode(n_min_tens);
            r_out_led <= n_led;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.seg_seconds_ones = r_seg_so;
    assign o_out.seg_seconds_tens = r_seg_st;
    assign o_out.seg_minutes_ones = r_seg_mo;
    assign o_out.seg_minutes_tens = r_seg_mt;
    assign o_out.led_byte         = r_out_led;

`ifndef NO_ASSERTIONS
    // The BCD counters never leave their decimal ranges.
    a_digits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec_ones <= 4'd9 && r_sec_tens <= 3'd5 && r_min_ones <= 4'd9 && r_min_tens <= 4'd9)
        else $error("stopwatch digit out of range");

    // A stopped watch does not count ticks.
    a_stopped_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && !r_running |=> $stable(r_prescaler))
        else $error("prescaler moved while stopped");

    // An accepted sample always occupies the input register next cycle.
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted beat lost");

    // The LED byte only changes on a second.
    a_led_on_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && !sec_pulse |=> $stable(r_led))
        else $error("LED byte changed without a second");
`endif

endmodule

// ===== verif/stopwatch_mm_ss_with_led_view_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// stopwatch_mm_ss_with_led_view_tb
// Self-checking bench for the mm:ss stopwatch with LED bar view.
// ============================================================================
// Button and tick samples are pushed through the input channel with random
// gaps, and display beats are taken with random back-pressure. Every accepted
// sample is run through a behavioural copy of the stopwatch kept in this file.
// Its display is queued, and each display beat is compared byte by byte with
// the oldest queued one. A directed table comes first. Random press sequences
// follow under several ticks-per-second settings. A run at one tick per
// second then carries the minutes past four, with view presses sprinkled in.
module stopwatch_mm_ss_with_led_view_tb;
    import swled_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_AFTER_BEATS = 300;
    localparam int HOLD_CYCLES = 150;
    localparam int PRINT_LIMIT = 40;

    // One sample of the tick flag and the three button levels.
    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
        logic view;
    } t_sample;

    // The four digit patterns and the LED byte of one display beat.
    typedef struct packed {
        logic [7:0] s1;
        logic [7:0] s10;
        logic [7:0] m1;
        logic [7:0] m10;
        logic [7:0] led;
    } t_display;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] cfg_val;
        t_sample    smp;
        logic       has_lit;
        t_display   lit;
    } t_row;

    localparam logic [7:0] SEG_LUT [16] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h80, 8'h90, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
    };

    // 00:00 with the decimal point lit and the LED bar dark.
    localparam t_display SHOW_ZERO = '{8'hc0, 8'hc0, 8'h40, 8'hc0, 8'h00};

    // Directed table; samples are written as {tick, start, stop, view}.
    localparam int DIR_ROWS = 28;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{ROW_ITEM, 8'd0,   4'b0000, 1'b1, SHOW_ZERO},  // state straight after reset
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b1, SHOW_ZERO},  // tick while stopped is ignored
        '{ROW_ITEM, 8'd0,   4'b0010, 1'b1, SHOW_ZERO},  // stop while stopped clears
        '{ROW_ITEM, 8'd0,   4'b0000, 1'b1, SHOW_ZERO},
        '{ROW_CFG,  8'd1,   4'b0000, 1'b0, '0},         // one tick a second, the fastest count
        '{ROW_ITEM, 8'd0,   4'b1110, 1'b1, SHOW_ZERO},  // start and stop together
        '{ROW_ITEM, 8'd0,   4'b0000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b0001, 1'b0, '0},         // view to packed mode
        '{ROW_ITEM, 8'd0,   4'b0100, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1100, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1001, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1001, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1001, 1'b0, '0},         // view wraps back to off
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b0010, 1'b0, '0},         // stop while running
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_CFG,  8'd255, 4'b0000, 1'b0, '0},         // slowest rate
        '{ROW_ITEM, 8'd0,   4'b0100, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_CFG,  8'd2,   4'b0000, 1'b0, '0},         // rate now below the count
        '{ROW_ITEM, 8'd0,   4'b1000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b1111, 1'b0, '0},         // everything at once
        '{ROW_ITEM, 8'd0,   4'b0000, 1'b0, '0},
        '{ROW_ITEM, 8'd0,   4'b0010, 1'b0, '0}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    swled_in_if  in_if ();
    swled_out_if out_if ();

    stopwatch_mm_ss_with_led_view u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // Stopwatch state as the bench believes it to be.
    logic [7:0] pre_cnt  = '0;
    t_digit     s_one    = '0;
    logic [2:0] s_ten    = '0;
    t_digit     m_one    = '0;
    t_digit     m_ten    = '0;
    logic       run_flag = 1'b0;
    logic [2:0] btn_prev = '0;
    logic [1:0] led_mode = VIEW_OFF;
    logic [7:0] led_val  = '0;
    logic [7:0] tps_val  = TPS_RESET;

    t_display pending_displays [$];
    int       fail_count   = 0;
    int       shown_beats  = 0;
    int       quiet_cycles = 0;
    logic     steady_phase = 1'b0;

    // Random press generator: level and remaining hold time of each button.
    logic [2:0] held_level   = '0;
    int         hold_left [3] = '{0, 0, 0};

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_failure(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // One second: BCD carry through the digits, then the LED bar refresh.
    function automatic void advance_clock();
        if (s_one == 4'd9) begin
            s_one = '0;
            if (s_ten == 3'd5) begin
                s_ten = '0;
                if (m_one == 4'd9) begin
                    m_one = '0;
                    m_ten = (m_ten == 4'd9) ? 4'd0 : m_ten + 4'd1;
                end else begin
                    m_one = m_one + 4'd1;
                end
            end else begin
                s_ten = s_ten + 3'd1;
            end
        end else begin
            s_one = s_one + 4'd1;
        end
        // The packed view only fits up to three minutes.
        if (led_mode == VIEW_PACKED && (m_one > 4'd3 || m_ten != 4'd0))
            led_mode = VIEW_MINUTES;
        case (led_mode)
            VIEW_OFF:     led_val = '0;
            VIEW_PACKED:  led_val = 8'(int'(s_one) + 10 * int'(s_ten) + 64 * int'(m_one));
            VIEW_MINUTES: led_val = 8'(int'(m_one) + 10 * int'(m_ten));
            default:      led_val = 8'(int'(s_one) + 10 * int'(s_ten));
        endcase
    endfunction

    // Applies one sample to the stopwatch state and returns the display shown.
    function automatic t_display step_watch(input t_sample s);
        logic [2:0] now;
        logic [2:0] rise;
        t_display   d;
        now  = {s.view, s.stop, s.start};
        rise = now & ~btn_prev;
        if (s.tick && run_flag) begin
            pre_cnt = pre_cnt + 8'd1;
            if (pre_cnt >= tps_val) begin
                pre_cnt = '0;
                advance_clock();
            end
        end
        if (rise[0])
            run_flag = 1'b1;
        if (rise[1]) begin
            if (run_flag) begin
                run_flag = 1'b0;
            end else begin
                s_one = '0;
                s_ten = '0;
                m_one = '0;
                m_ten = '0;
            end
        end
        if (rise[2])
            led_mode = (led_mode == VIEW_SECONDS) ? VIEW_OFF : led_mode + 2'd1;
        btn_prev = now;
        d.s1  = SEG_LUT[s_one];
        d.s10 = SEG_LUT[{1'b0, s_ten}];
        d.m1  = SEG_LUT[m_one] ^ SEG_DP;
        d.m10 = SEG_LUT[m_ten];
        d.led = led_val;
        return d;
    endfunction

    // Mostly well-formed presses held for a few samples; some pure noise.
    function automatic t_sample next_press_sample();
        t_sample s;
        int      k;
        int      pct;
        if ($urandom_range(0, 99) < 15) begin
            s = t_sample'(4'($urandom_range(0, 15)));
            return s;
        end
        for (k = 0; k < 3; k++) begin
            pct = (k == 1) ? 3 : 6;
            if (hold_left[k] > 0) begin
                hold_left[k]--;
            end else if (held_level[k]) begin
                held_level[k] = 1'b0;
                hold_left[k]  = $urandom_range(0, 3);
            end else if ($urandom_range(0, 99) < pct) begin
                held_level[k] = 1'b1;
                hold_left[k]  = $urandom_range(0, 3);
            end
        end
        s.tick  = ($urandom_range(0, 99) < 85);
        s.start = held_level[0];
        s.stop  = held_level[1];
        s.view  = held_level[2];
        return s;
    endfunction

    function automatic int pick_sender_gap();
        int r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input t_sample s, input logic has_lit, input t_display lit);
        int       gap;
        t_display d;
        gap = pick_sender_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.timer_tick  <= s.tick;
        in_if.start_level <= s.start;
        in_if.stop_level  <= s.stop;
        in_if.view_level  <= s.view;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        d = step_watch(s);
        pending_displays.push_back(has_lit ? lit : d);
        @(negedge clk);
    endtask

    // Stops offering and waits until every queued display has been seen.
    task automatic drain_displays();
        in_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_displays.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_rate(input logic [7:0] v);
        drain_displays();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tps_val = v;
        @(negedge clk);
    endtask

    // Display side: compare each beat with the oldest queued display.
    always @(posedge clk) begin : check_display
        t_display    got;
        t_display    want;
        int          k;
        string       names [5];
        names = '{"seg_seconds_ones", "seg_seconds_tens", "seg_minutes_ones",
                  "seg_minutes_tens", "led_byte"};
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            shown_beats++;
            got = {out_if.seg_seconds_ones, out_if.seg_seconds_tens,
                   out_if.seg_minutes_ones, out_if.seg_minutes_tens, out_if.led_byte};
            if (pending_displays.size() == 0) begin
                report_failure($sformatf("display beat %h with no sample pending", got));
            end else begin
                want = pending_displays.pop_front();
                for (k = 0; k < 5; k++) begin
                    if (got[39 - 8 * k -: 8] !== want[39 - 8 * k -: 8])
                        report_failure($sformatf("beat %0d %s got %h want %h", shown_beats,
                                       names[k], got[39 - 8 * k -: 8], want[39 - 8 * k -: 8]));
                end
            end
        end
    end

    // Display side back-pressure, with one long hold-off that fills the block.
    initial begin : drive_ready
        logic held_off;
        held_off = 1'b0;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (!held_off && shown_beats >= HOLD_AFTER_BEATS) begin
                held_off = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_if.ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 8)) @(negedge clk);
            out_if.ready <= 1'b0;
            repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 2)) @(negedge clk);
        end
    end

    // Watchdog: give up once nothing has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || cfg_wr_en || (in_if.valid === 1'b1 && in_if.ready === 1'b1)
            || (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus: directed table, random press phases, then a run past four minutes.
    initial begin : stimulus
        int         p;
        int         i;
        int         r;
        t_row       row;
        t_sample    s;
        logic [7:0] rate;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        in_if.valid       = 1'b0;
        in_if.timer_tick  = 1'b0;
        in_if.start_level = 1'b0;
        in_if.stop_level  = 1'b0;
        in_if.view_level  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
                write_rate(row.cfg_val);
            else
                send_sample(row.smp, row.has_lit, row.lit);
        end

        // Random phases, each under its own rate, mostly fast ones.
        for (p = 0; p < 8; p++) begin
            r = $urandom_range(0, 9);
            if (r < 5)
                rate = 8'($urandom_range(1, 3));
            else if (r == 5)
                rate = 8'd1;
            else if (r == 6)
                rate = 8'd255;
            else if (r == 7)
                rate = TPS_RESET;
            else
                rate = 8'($urandom_range(1, 255));
            write_rate(rate);
            steady_phase = ($urandom_range(0, 4) == 0);
            for (i = 0; i < 90; i++) begin
                s = next_press_sample();
                send_sample(s, 1'b0, '0);
            end
        end

        // Clear the watch, then run past four minutes with view presses sprinkled in.
        write_rate(8'd1);
        steady_phase = 1'b0;
        send_sample(4'b0010, 1'b0, '0);
        send_sample(4'b0000, 1'b0, '0);
        send_sample(4'b0010, 1'b0, '0);
        send_sample(4'b0000, 1'b0, '0);
        send_sample(4'b0100, 1'b0, '0);
        for (i = 0; i < 260; i++) begin
            s = 4'b1000;
            s.view = (i % 50 == 25);
            send_sample(s, 1'b0, '0);
        end

        drain_displays();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
